// ===== rtl/fdss_pkg.sv =====
// Shared types, constants and helper functions of the decimal segment scan block.
// Depends on nothing; every other file of the block refers to it by scoped names.
`default_nettype none

package fdss_pkg;

    localparam int VALUE_W = 14;
    localparam int REP_W   = 4;
    localparam int SEG_W   = 8;
    localparam int SEL_W   = 4;
    localparam int DIG_W   = 4;
    localparam int IDX_W   = 2;

    localparam int Q_DEPTH = 2;
    localparam int Q_AW    = 1;
    localparam int Q_CW    = 2;

    localparam logic [15:0] DIV10_MUL   = 16'd52429;
    localparam int          DIV10_SHIFT = 19;

    localparam logic [SEL_W-1:0] SEL_UNITS = 4'b0001;
    localparam logic [SEL_W-1:0] SEL_THOUS = 4'b1000;

    localparam logic [SEG_W-1:0] SEG_BLANK = 8'hFF;

    localparam logic [SEG_W-1:0] SEG_TABLE [10] = '{
        8'hC0, 8'hF9, 8'hA4, 8'hB0, 8'h99, 8'h92, 8'h82, 8'hF8, 8'h80, 8'h90
    };

    localparam logic [VALUE_W-1:0] POW10 [SEL_W] = '{
        14'd1, 14'd10, 14'd100, 14'd1000
    };

    typedef struct packed {
        logic [SEL_W-1:0][SEG_W-1:0] pat;
        logic [IDX_W-1:0]            last_idx;
        logic [REP_W-1:0]            rep;
    } t_job;

    function automatic logic [VALUE_W-1:0] div10(input logic [VALUE_W-1:0] x);
        logic [29:0] p;
        p = 30'(x) * 30'(DIV10_MUL);
        return VALUE_W'(p >> DIV10_SHIFT);
    endfunction

    function automatic logic [SEG_W-1:0] seg_of(input logic [DIG_W-1:0] d);
        logic [SEG_W-1:0] s;
        s = SEG_BLANK;
        if (d <= DIG_W'(9)) begin
            s = SEG_TABLE[d];
        end
        return s;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/fdss_if.sv =====
// Request channel interfaces of the decimal segment scan block.
// Depends on fdss_pkg for the field widths.
`default_nettype none

interface fdss_in_if;
    logic                             valid;
    logic                             ready;
    logic [fdss_pkg::VALUE_W-1:0]     value;
    logic [fdss_pkg::REP_W-1:0]       repeat_count;
    logic                             show_zero;

    modport source (output valid, value, repeat_count, show_zero, input ready);
    modport sink   (input valid, value, repeat_count, show_zero, output ready);
endinterface

interface fdss_out_if;
    logic                             valid;
    logic                             ready;
    logic [fdss_pkg::SEG_W-1:0]       segments;
    logic [fdss_pkg::SEL_W-1:0]       digit_select;
    logic                             last;

    modport source (output valid, segments, digit_select, last, input ready);
    modport sink   (input valid, segments, digit_select, last, output ready);
endinterface

`default_nettype wire

// ===== rtl/fdss_front.sv =====
// Front end: accepts requests, splits the value into decimal digits one digit per stage,
// and hands a ready-to-scan job to the queue. Depends on fdss_pkg and fdss_if.
`default_nettype none

module fdss_front #(
    parameter int DIGITS = 4
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    fdss_in_if.sink              i_in,
    output      logic            o_q_valid,
    output      fdss_pkg::t_job  o_q_job,
    input  wire logic            i_q_ready
);

    localparam int ND = (DIGITS < 1) ? 1 : ((DIGITS > fdss_pkg::SEL_W) ? fdss_pkg::SEL_W : DIGITS);
    localparam int NS = 4;

    logic [NS-1:0]                                   r_v;
    logic [fdss_pkg::VALUE_W-1:0]                    r_x    [NS];
    logic [fdss_pkg::SEL_W-1:0][fdss_pkg::DIG_W-1:0] r_dig  [NS];
    logic [fdss_pkg::REP_W-1:0]                      r_rep  [NS];
    logic [fdss_pkg::IDX_W-1:0]                      r_lidx [NS];

    logic [NS-1:0]                                   adv;
    logic [fdss_pkg::VALUE_W-1:0]                    q      [NS-1];
    logic [fdss_pkg::SEL_W-1:0][fdss_pkg::DIG_W-1:0] dig_n  [NS-1];
    logic [fdss_pkg::IDX_W-1:0]                      lidx;
    logic [fdss_pkg::DIG_W-1:0]                      top_dig;
    logic [fdss_pkg::VALUE_W-1:0]                    prod10;

    always_comb begin
        adv[NS-1] = !r_v[NS-1] || i_q_ready;
        for (int i = NS - 2; i >= 0; i--) begin
            adv[i] = !r_v[i] || adv[i+1];
        end
    end

    assign i_in.ready = adv[0];

    // The last digit position shown is the highest one allowed by show_zero or by the full value.
    always_comb begin
        lidx = '0;
        for (int k = 1; k < ND; k++) begin
            if (i_in.show_zero || (i_in.value >= fdss_pkg::POW10[k])) begin
                lidx = fdss_pkg::IDX_W'(k);
            end
        end
    end

    always_comb begin
        for (int i = 0; i < NS - 1; i++) begin
            q[i]        = fdss_pkg::div10(r_x[i]);
            prod10      = (q[i] << 3) + (q[i] << 1);
            dig_n[i]    = r_dig[i];
            dig_n[i][i] = fdss_pkg::DIG_W'(r_x[i] - prod10);
        end
    end

    // The thousands quotient stays below 17, so one subtraction finishes the digit.
    assign top_dig = (r_x[NS-1] >= fdss_pkg::VALUE_W'(10))
                   ? fdss_pkg::DIG_W'(r_x[NS-1] - fdss_pkg::VALUE_W'(10))
                   : fdss_pkg::DIG_W'(r_x[NS-1]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (adv[0]) begin
                r_v[0] <= i_in.valid;
            end
            for (int i = 1; i < NS; i++) begin
                if (adv[i]) begin
                    r_v[i] <= r_v[i-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv[0] && i_in.valid) begin
            r_x[0]    <= i_in.value;
            r_dig[0]  <= '0;
            r_rep[0]  <= i_in.repeat_count;
            r_lidx[0] <= lidx;
        end
        for (int i = 1; i < NS; i++) begin
            if (adv[i] && r_v[i-1]) begin
                r_x[i]    <= q[i-1];
                r_dig[i]  <= dig_n[i-1];
                r_rep[i]  <= r_rep[i-1];
                r_lidx[i] <= r_lidx[i-1];
            end
        end
    end

    always_comb begin
        o_q_job.last_idx = r_lidx[NS-1];
        o_q_job.rep      = r_rep[NS-1];
        for (int k = 0; k < NS - 1; k++) begin
            o_q_job.pat[k] = fdss_pkg::seg_of(r_dig[NS-1][k]);
        end
        o_q_job.pat[NS-1] = fdss_pkg::seg_of(top_dig);
    end

    assign o_q_valid = r_v[NS-1];

endmodule

`default_nettype wire

// ===== rtl/fdss_queue.sv =====
// Two-entry job queue between the digit front end and the scan sequencer.
// Depends on fdss_pkg for the job type and depth constants.
`default_nettype none

module fdss_queue (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push_valid,
    input  wire fdss_pkg::t_job  i_push_job,
    output      logic            o_push_ready,
    output      logic            o_pop_valid,
    output      fdss_pkg::t_job  o_pop_job,
    input  wire logic            i_pop_ready
);

    fdss_pkg::t_job                r_mem [fdss_pkg::Q_DEPTH];
    logic [fdss_pkg::Q_AW-1:0]     r_wp;
    logic [fdss_pkg::Q_AW-1:0]     r_rp;
    logic [fdss_pkg::Q_CW-1:0]     r_cnt;
    logic [fdss_pkg::Q_CW-1:0]     n_cnt;
    logic                          push;
    logic                          pop;

    assign o_push_ready = (r_cnt != fdss_pkg::Q_CW'(fdss_pkg::Q_DEPTH));
    assign o_pop_valid  = (r_cnt != '0);
    assign o_pop_job    = r_mem[r_rp];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_comb begin
        n_cnt = r_cnt;
        if (push && !pop) begin
            n_cnt = r_cnt + fdss_pkg::Q_CW'(1);
        end else if (pop && !push) begin
            n_cnt = r_cnt - fdss_pkg::Q_CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (push) begin
                r_wp <= r_wp + fdss_pkg::Q_AW'(1);
            end
            if (pop) begin
                r_rp <= r_rp + fdss_pkg::Q_AW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_push_job;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/fdss_back.sv =====
// Back end: scan sequencer that emits one segment and select pair per cycle, unless the output
// stalls, into an output register. Depends on fdss_pkg and fdss_if.
`default_nettype none

module fdss_back (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_q_valid,
    input  wire fdss_pkg::t_job  i_q_job,
    output      logic            o_q_ready,
    fdss_out_if.source           o_out
);

    logic                          r_busy;
    fdss_pkg::t_job                r_job;
    logic [fdss_pkg::IDX_W-1:0]    r_k;
    logic [fdss_pkg::REP_W-1:0]    r_r;
    logic                          r_ov;
    logic [fdss_pkg::SEG_W-1:0]    r_seg;
    logic [fdss_pkg::SEL_W-1:0]    r_sel;
    logic                          r_last;

    logic                          slot_free;
    logic                          fire;
    logic                          round_end;
    logic                          job_end;
    logic                          take;

    assign slot_free = !r_ov || o_out.ready;
    assign fire      = r_busy && slot_free;
    assign round_end = (r_k == r_job.last_idx);
    assign job_end   = round_end && (r_r == r_job.rep);
    assign o_q_ready = !r_busy || (fire && job_end);
    assign take      = i_q_valid && o_q_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_ov   <= 1'b0;
            r_k    <= '0;
            r_r    <= '0;
        end else begin
            if (take) begin
                r_busy <= 1'b1;
                r_k    <= '0;
                r_r    <= '0;
            end else if (fire && job_end) begin
                r_busy <= 1'b0;
            end else if (fire) begin
                if (round_end) begin
                    r_k <= '0;
                    r_r <= r_r + fdss_pkg::REP_W'(1);
                end else begin
                    r_k <= r_k + fdss_pkg::IDX_W'(1);
                end
            end
            if (fire) begin
                r_ov <= 1'b1;
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_job <= i_q_job;
        end
        if (fire) begin
            r_seg  <= r_job.pat[r_k];
            r_sel  <= fdss_pkg::SEL_UNITS << r_k;
            r_last <= job_end;
        end
    end

    assign o_out.valid        = r_ov;
    assign o_out.segments     = r_seg;
    assign o_out.digit_select = r_sel;
    assign o_out.last         = r_last;

endmodule

`default_nettype wire

// ===== rtl/four_digit_decimal_segment_scan.sv =====
// Top level of the four-digit decimal seven-segment scan driver.
// Depends on fdss_pkg, fdss_if, fdss_front, fdss_queue and fdss_back.
//
//  Channel | Direction | Payload                              | Handshake
//  i_in    | in        | value, repeat_count, show_zero       | valid / ready
//  o_out   | out       | segments, digit_select, last         | valid / ready
//
// A request passes through the stages of the digit pipeline, one digit divided off per stage.
// The scan sequencer gives one result per cycle unless the output stalls, so a request with
// n shown digits and repeat count r gives n * (r+1) results; requests follow back to back.
// A two-entry queue lets the front keep accepting while the sequencer is stalled.
// Reset is synchronous and clears only the valid flags and counters.
`default_nettype none

module four_digit_decimal_segment_scan #(
    parameter int DIGITS = 4
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    fdss_in_if.sink    i_in,
    fdss_out_if.source o_out
);

    logic            f_valid;
    logic            f_ready;
    fdss_pkg::t_job  f_job;
    logic            b_valid;
    logic            b_ready;
    fdss_pkg::t_job  b_job;

    fdss_front #(
        .DIGITS (DIGITS)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .o_q_valid (f_valid),
        .o_q_job   (f_job),
        .i_q_ready (f_ready)
    );

    fdss_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (f_valid),
        .i_push_job   (f_job),
        .o_push_ready (f_ready),
        .o_pop_valid  (b_valid),
        .o_pop_job    (b_job),
        .i_pop_ready  (b_ready)
    );

    fdss_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (b_valid),
        .i_q_job   (b_job),
        .o_q_ready (b_ready),
        .o_out     (o_out)
    );

endmodule

`default_nettype wire

// ===== rtl/fdss_checker.sv =====
// Port-level checker for the decimal segment scan block, bound to its top level.
// Depends on fdss_pkg for field widths.
`default_nettype none

module fdss_checker (
    input wire logic                         i_clk,
    input wire logic                         i_rst_n,
    input wire logic                         i_in_valid,
    input wire logic                         i_in_ready,
    input wire logic                         i_out_valid,
    input wire logic                         i_out_ready,
    input wire logic [fdss_pkg::SEG_W-1:0]   i_out_segments,
    input wire logic [fdss_pkg::SEL_W-1:0]   i_out_digit_select,
    input wire logic                         i_out_last
);

    logic                        r_mid;
    logic [fdss_pkg::SEL_W-1:0]  r_prev_sel;
    logic [3:0]                  r_pend;
    logic                        in_acc;
    logic                        out_acc;

    assign in_acc  = i_in_valid && i_in_ready;
    assign out_acc = i_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mid      <= 1'b0;
            r_prev_sel <= '0;
            r_pend     <= '0;
        end else begin
            r_pend <= r_pend + 4'(in_acc) - 4'(out_acc && i_out_last);
            if (out_acc) begin
                r_mid      <= !i_out_last;
                r_prev_sel <= i_out_digit_select;
            end
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_segments)
            && $stable(i_out_digit_select) && $stable(i_out_last))
        else $error("result changed while stalled");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> r_pend != 4'd0)
        else $error("result with no request outstanding");

    a_units_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !r_mid |-> i_out_digit_select == fdss_pkg::SEL_UNITS)
        else $error("request does not start with the units digit");

    a_scan_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && r_mid |-> (i_out_digit_select == fdss_pkg::SEL_UNITS)
            || ((i_out_digit_select == (r_prev_sel << 1))
                && (r_prev_sel != fdss_pkg::SEL_THOUS)))
        else $error("digit select out of scan order");

endmodule

bind four_digit_decimal_segment_scan fdss_checker u_fdss_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_in_valid         (i_in.valid),
    .i_in_ready         (i_in.ready),
    .i_out_valid        (o_out.valid),
    .i_out_ready        (o_out.ready),
    .i_out_segments     (o_out.segments),
    .i_out_digit_select (o_out.digit_select),
    .i_out_last         (o_out.last)
);

`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking testbench of the four-digit decimal segment scan block.
// Depends on fdss_pkg, fdss_if and the four_digit_decimal_segment_scan top level.
`timescale 1ns / 1ps

module tb;

    localparam int VALUE_W = fdss_pkg::VALUE_W;
    localparam int REP_W   = fdss_pkg::REP_W;
    localparam int SEG_W   = fdss_pkg::SEG_W;
    localparam int SEL_W   = fdss_pkg::SEL_W;

    localparam int CYCLE_LIMIT = 300000;
    localparam int LONG_HOLD   = 400;
    localparam int HOLD_AFTER  = 60;
    localparam int DRAIN_WAIT  = 16;

    localparam logic [SEG_W-1:0] GLYPH [10] = '{
        8'hC0, 8'hF9, 8'hA4, 8'hB0, 8'h99, 8'h92, 8'h82, 8'hF8, 8'h80, 8'h90
    };

    typedef struct {
        logic [VALUE_W-1:0] value;
        logic [REP_W-1:0]   repeat_count;
        logic               show_zero;
    } t_display_req;

    typedef struct {
        logic [SEG_W-1:0] segments;
        logic [SEL_W-1:0] digit_select;
        logic             last;
    } t_scan_digit;

    logic i_clk = 1'b0;
    logic i_rst_n;

    fdss_in_if  req_bus ();
    fdss_out_if seg_bus ();

    four_digit_decimal_segment_scan DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_bus),
        .o_out   (seg_bus)
    );

    t_display_req requests_pending [$];
    t_scan_digit  scan_expected [$];

    int requests_total = 0;
    int requests_taken = 0;
    int errors         = 0;
    int cycles         = 0;

    int  send_gap;
    bit  send_calm;
    int  recv_gap;
    bit  recv_calm;
    int  hold_left;
    bit  hold_done;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic int draw_gap(input bit calm);
        return calm ? 0 : $urandom_range(0, 4);
    endfunction

    task automatic predict_scan(input t_display_req req);
        logic [SEG_W-1:0] pat [SEL_W];
        int               full;
        int               rem;
        int               pow;
        int               shown;
        t_scan_digit      d;
        full  = int'(req.value);
        rem   = full % 10000;
        pow   = 1;
        shown = 1;
        for (int k = 0; k < SEL_W; k++) begin
            pat[k] = GLYPH[rem % 10];
            rem    = rem / 10;
            if (k > 0 && (req.show_zero || full >= pow)) begin
                shown = k + 1;
            end
            pow = pow * 10;
        end
        for (int r = 0; r <= int'(req.repeat_count); r++) begin
            for (int k = 0; k < shown; k++) begin
                d.segments     = pat[k];
                d.digit_select = SEL_W'(1) << k;
                d.last         = (r == int'(req.repeat_count)) && (k == shown - 1);
                scan_expected.push_back(d);
            end
        end
    endtask

    task automatic queue_request(input int value, input int rep, input bit show_zero);
        t_display_req req;
        req.value        = VALUE_W'(value);
        req.repeat_count = REP_W'(rep);
        req.show_zero    = show_zero;
        requests_pending.push_back(req);
        requests_total++;
    endtask

    always @(posedge i_clk) begin : driver
        t_display_req req;
        if (!i_rst_n) begin
            req_bus.valid <= 1'b0;
            send_gap      <= 0;
            send_calm     <= 1'b0;
        end else begin
            if (req_bus.valid && req_bus.ready) begin
                req.value        = req_bus.value;
                req.repeat_count = req_bus.repeat_count;
                req.show_zero    = req_bus.show_zero;
                predict_scan(req);
                requests_taken <= requests_taken + 1;
            end
            if (!req_bus.valid || req_bus.ready) begin
                if (send_gap != 0) begin
                    send_gap      <= send_gap - 1;
                    req_bus.valid <= 1'b0;
                end else if (requests_pending.size() != 0) begin
                    req = requests_pending.pop_front();
                    req_bus.valid        <= 1'b1;
                    req_bus.value        <= req.value;
                    req_bus.repeat_count <= req.repeat_count;
                    req_bus.show_zero    <= req.show_zero;
                    send_gap             <= draw_gap(send_calm);
                    if ($urandom_range(0, 19) == 0) begin
                        send_calm <= !send_calm;
                    end
                end else begin
                    req_bus.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : long_stall
        if (!i_rst_n) begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (!hold_done && requests_taken >= HOLD_AFTER) begin
            hold_left <= LONG_HOLD;
            hold_done <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    always @(posedge i_clk) begin : monitor
        int          g;
        t_scan_digit want;
        if (!i_rst_n) begin
            seg_bus.ready <= 1'b0;
            recv_gap      <= 0;
            recv_calm     <= 1'b0;
        end else begin
            g = recv_gap;
            if (seg_bus.valid && seg_bus.ready) begin
                if (scan_expected.size() == 0) begin
                    $error("unexpected result: segments %h digit_select %b last %b",
                           seg_bus.segments, seg_bus.digit_select, seg_bus.last);
                    errors++;
                end else begin
                    want = scan_expected.pop_front();
                    if (seg_bus.segments !== want.segments) begin
                        $error("segments: expected %h, actual %h",
                               want.segments, seg_bus.segments);
                        errors++;
                    end
                    if (seg_bus.digit_select !== want.digit_select) begin
                        $error("digit_select: expected %b, actual %b",
                               want.digit_select, seg_bus.digit_select);
                        errors++;
                    end
                    if (seg_bus.last !== want.last) begin
                        $error("last: expected %b, actual %b", want.last, seg_bus.last);
                        errors++;
                    end
                end
                g = draw_gap(recv_calm);
                if ($urandom_range(0, 29) == 0) begin
                    recv_calm <= !recv_calm;
                end
            end else if (g != 0) begin
                g = g - 1;
            end
            recv_gap      <= g;
            seg_bus.ready <= (g == 0) && (hold_left == 0);
        end
    end

    always @(posedge i_clk) begin : watchdog
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("four_digit_decimal_segment_scan regression: fail");
            $finish;
        end
    end

    initial begin : stimulus
        int v;
        int rep;
        i_rst_n = 1'b0;

        queue_request(0, 0, 1'b0);
        queue_request(0, 1, 1'b1);
        queue_request(9, 0, 1'b0);
        queue_request(10, 0, 1'b0);
        queue_request(99, 2, 1'b0);
        queue_request(100, 0, 1'b0);
        queue_request(999, 0, 1'b0);
        queue_request(1000, 0, 1'b0);
        queue_request(9999, 0, 1'b0);
        queue_request(10000, 0, 1'b0);
        queue_request(10009, 1, 1'b0);
        queue_request(16383, 15, 1'b1);
        queue_request(16383, 0, 1'b0);
        queue_request(1234, 3, 1'b0);
        queue_request(5678, 0, 1'b1);
        queue_request(9012, 0, 1'b0);
        queue_request(7, 15, 1'b0);
        queue_request(7, 2, 1'b1);
        queue_request(405, 0, 1'b1);
        queue_request(60, 1, 1'b0);

        for (int n = 0; n < 200; n++) begin
            case ($urandom_range(0, 3))
                0: v = $urandom_range(0, 99);
                1: v = $urandom_range(0, 9999);
                2: v = $urandom_range(0, 16383);
                default: v = (10 ** $urandom_range(1, 4)) + $urandom_range(0, 2) - 1;
            endcase
            rep = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 2);
            queue_request(v, rep, $urandom_range(0, 1));
        end

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (requests_taken < requests_total || scan_expected.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (scan_expected.size() != 0) begin
            $error("%0d expected results never arrived", scan_expected.size());
        end
        if (errors == 0 && scan_expected.size() == 0) begin
            $display("four_digit_decimal_segment_scan regression: pass");
        end else begin
            $display("four_digit_decimal_segment_scan regression: fail");
        end
        $finish;
    end

endmodule
